// File: hw/rtl/deque_with_search_remove_top_assert.svh
// Assertion macros for the deque block checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef DEQUE_WITH_SEARCH_REMOVE_TOP_ASSERT_SVH
`define DEQUE_WITH_SEARCH_REMOVE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWSR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dwsr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DWSR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dwsr assertion failed");

`endif

// File: hw/rtl/dwsr_pkg.sv
// Shared types and constants for the deque with search and remove.
// No dependencies; used by the top level and the port checker.
package dwsr_pkg;

    localparam int FUNC_W      = 3;
    localparam int FIELD_W     = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int S_TDATA_W   = 40;   // 35 payload bits padded to whole bytes
    localparam int M_TDATA_W   = 72;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CONTAINS   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 3'd5;

    // Result layout, lowest bits last in the declaration.
    typedef struct packed {
        logic                   error;
        logic                   found;
        logic                   is_empty;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [FIELD_W-1:0]     back_value;
        logic [FIELD_W-1:0]     front_value;
    } result_t;

endpackage

// File: hw/rtl/dwsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/deque_with_search_remove_top.sv
// Top level of the bounded deque with membership search and remove-first-match.
// Depends on dwsr_pkg and dwsr_ram.
//
//  channel  dir  tdata fields (low bit up)                                  tlast/tuser
//  s_       in   func[2:0] value[34:3], pad to 40                            none
//  m_       out  front_value[31:0] back_value[63:32] entry_count[68:64]
//                is_empty[69] found[70] error[71]                            none
//
// One request in flight at a time; its result sits in an output register, and the
// next request is taken while that result waits for m_tready.
// Push: the request passes through the execute and done states. Pops: the same, with
// a front/back reload through RF0-RF2 unless the queue empties. Contains: a scan of the
// stored entries. Remove: scan to the first match and shift of the later entries one per
// cycle, then a reload of front and back through RF0-RF2. The single RAM read port
// sets this sequencing.
// Reset (aresetn low, synchronous) empties the queue; entry storage is not cleared.
module deque_with_search_remove_top #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dwsr_pkg::S_TDATA_W-1:0] s_tdata,   // func[2:0], value[34:3], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dwsr_pkg::M_TDATA_W-1:0] m_tdata    // front, back, count, empty, found, error
);

    import dwsr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = VALUE_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_RF0   = 3'd4;   // read front slot
    localparam logic [2:0] ST_RF1   = 3'd5;   // take front, read back slot
    localparam logic [2:0] ST_RF2   = 3'd6;   // take back
    localparam logic [2:0] ST_DONE  = 3'd7;

    // Circular slot of position pos from the front.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, pos};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [VW-1:0]     key_reg, key_next;
    logic [AW-1:0]     front_idx_reg, front_idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [VW-1:0]     front_val_reg, front_val_next;
    logic [VW-1:0]     back_val_reg, back_val_next;
    logic [CW-1:0]     issue_reg, issue_next;   // next scan position to read
    logic [CW-1:0]     cmp_reg, cmp_next;       // position whose data is arriving
    logic              pend_reg, pend_next;
    logic [CW-1:0]     k_reg, k_next;           // shift write position
    logic              found_reg, found_next;
    logic              error_reg, error_next;
    logic              m_tvalid_reg, m_tvalid_next;
    result_t           m_tdata_reg, m_tdata_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [VW-1:0]     mem_wdata, mem_rdata;

    logic              cnt_zero, cnt_full, cnt_one;
    logic [CW-1:0]     cnt_m1, cnt_p1, cmp_p1, k_p1, k_p2;
    logic [AW-1:0]     last_pos, prev_front, next_front;
    logic              hit;
    logic [63:0]       front_ext, back_ext;
    result_t           res;

    dwsr_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cnt_zero   = (count_reg == '0);
    assign cnt_full   = (count_reg == CW'(DEPTH));
    assign cnt_one    = (count_reg == CW'(1));
    assign cnt_m1     = count_reg - CW'(1);
    assign cnt_p1     = count_reg + CW'(1);
    assign cmp_p1     = cmp_reg + CW'(1);
    assign k_p1       = k_reg + CW'(1);
    assign k_p2       = k_reg + CW'(2);
    assign last_pos   = cnt_m1[AW-1:0];
    assign prev_front = (front_idx_reg == '0) ? AW'(DEPTH - 1) : front_idx_reg - AW'(1);
    assign next_front = (front_idx_reg == AW'(DEPTH - 1)) ? '0 : front_idx_reg + AW'(1);
    assign hit        = pend_reg && (mem_rdata == key_reg);

    // Result word built from the cached ends; an empty queue reports zeros.
    assign front_ext = 64'(front_val_reg);
    assign back_ext  = 64'(back_val_reg);
    always_comb begin
        res.front_value = cnt_zero ? '0 : front_ext[FIELD_W-1:0];
        res.back_value  = cnt_zero ? '0 : back_ext[FIELD_W-1:0];
        res.entry_count = COUNT_OUT_W'(count_reg);
        res.is_empty    = cnt_zero;
        res.found       = found_reg;
        res.error       = error_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        front_idx_next = front_idx_reg;
        count_next     = count_reg;
        front_val_next = front_val_reg;
        back_val_next  = back_val_reg;
        issue_next     = issue_reg;
        cmp_next       = cmp_reg;
        pend_next      = pend_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        error_next     = error_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_waddr      = front_idx_reg;
        mem_wdata      = key_reg;
        mem_raddr      = front_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tdata[FUNC_W-1:0];
                    key_next   = VW'(64'(s_tdata[FUNC_W +: FIELD_W]));
                    found_next = 1'b0;
                    error_next = 1'b0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                unique case (func_reg) inside
                    FUNC_PUSH_FRONT: begin
                        if (cnt_full) begin
                            error_next = 1'b1;
                        end else begin
                            mem_we         = 1'b1;
                            mem_waddr      = prev_front;
                            front_idx_next = prev_front;
                            front_val_next = key_reg;
                            if (cnt_zero) begin
                                back_val_next = key_reg;
                            end
                            count_next = cnt_p1;
                        end
                    end
                    FUNC_PUSH_BACK: begin
                        if (cnt_full) begin
                            error_next = 1'b1;
                        end else begin
                            mem_we        = 1'b1;
                            mem_waddr     = slot_of(front_idx_reg, count_reg[AW-1:0]);
                            back_val_next = key_reg;
                            if (cnt_zero) begin
                                front_val_next = key_reg;
                            end
                            count_next = cnt_p1;
                        end
                    end
                    FUNC_POP_FRONT: begin
                        if (cnt_zero) begin
                            error_next = 1'b1;
                        end else begin
                            front_idx_next = next_front;
                            count_next     = cnt_m1;
                            state_next     = cnt_one ? ST_DONE : ST_RF0;
                        end
                    end
                    FUNC_POP_BACK: begin
                        if (cnt_zero) begin
                            error_next = 1'b1;
                        end else begin
                            count_next = cnt_m1;
                            state_next = cnt_one ? ST_DONE : ST_RF0;
                        end
                    end
                    FUNC_CONTAINS, FUNC_REMOVE: begin
                        issue_next = '0;
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                // One read issued per cycle; its compare lands in the next cycle.
                if (hit) begin
                    found_next = 1'b1;
                    pend_next  = 1'b0;
                    if (func_reg != FUNC_REMOVE) begin
                        state_next = ST_DONE;
                    end else if (cmp_reg == cnt_m1) begin
                        count_next = cnt_m1;
                        state_next = cnt_one ? ST_DONE : ST_RF0;
                    end else begin
                        mem_raddr  = slot_of(front_idx_reg, cmp_p1[AW-1:0]);
                        k_next     = cmp_reg;
                        state_next = ST_SHIFT;
                    end
                end else if (issue_reg < count_reg) begin
                    mem_raddr  = slot_of(front_idx_reg, issue_reg[AW-1:0]);
                    pend_next  = 1'b1;
                    cmp_next   = issue_reg;
                    issue_next = issue_reg + CW'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                // Read data holds position k+1; write it down to position k.
                mem_we    = 1'b1;
                mem_waddr = slot_of(front_idx_reg, k_reg[AW-1:0]);
                mem_wdata = mem_rdata;
                if (k_p2 == count_reg) begin
                    count_next = cnt_m1;
                    state_next = ST_RF0;
                end else begin
                    mem_raddr = slot_of(front_idx_reg, k_p2[AW-1:0]);
                    k_next    = k_p1;
                end
            end
            ST_RF0: begin
                mem_raddr  = front_idx_reg;
                state_next = ST_RF1;
            end
            ST_RF1: begin
                front_val_next = mem_rdata;
                mem_raddr      = slot_of(front_idx_reg, last_pos);
                state_next     = ST_RF2;
            end
            ST_RF2: begin
                back_val_next = mem_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            front_idx_reg <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        front_val_reg <= front_val_next;
        back_val_reg  <= back_val_next;
        issue_reg     <= issue_next;
        cmp_reg       <= cmp_next;
        k_reg         <= k_next;
        found_reg     <= found_next;
        error_reg     <= error_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule

// File: hw/rtl/dwsr_checker.sv
// Port-level checker for the deque top level, bound into it below.
// Depends on dwsr_pkg and the assertion macro header.
`include "deque_with_search_remove_top_assert.svh"

module dwsr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [dwsr_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dwsr_pkg::M_TDATA_W-1:0] m_tdata
);

    import dwsr_pkg::*;

    result_t res;
    logic    s_fire;

    assign res    = result_t'(m_tdata);
    assign s_fire = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]);

    // Stalled result must hold.
    `DWSR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Empty queue reports zero ends and zero count.
    `DWSR_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_tvalid && res.is_empty, (res.front_value == '0) && (res.back_value == '0) && (res.entry_count == '0))

    // A rejected push or pop never reports a match.
    `DWSR_ASSERT_IMP(a_err_no_found, aclk, aresetn, m_tvalid && res.error, !res.found)

    // Only one request in flight: intake closes right after a transfer.
    `DWSR_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_fire, !s_tready)

endmodule

bind deque_with_search_remove_top dwsr_checker u_dwsr_checker (.*);
